// ===== rtl/core/lz4d_pkg.sv =====
package lz4d_pkg;

  localparam int HISTORY_BYTES_DEF = 65536;
  localparam int LANE_BYTES_DEF    = 8;
  localparam int BANKS             = 8;
  localparam int LEN_W             = 24;
  localparam logic [LEN_W-1:0] MAX24 = 24'hFFFFFF;

  localparam logic [1:0] REQ_BYTE    = 2'd0;
  localparam logic [1:0] REQ_DRAIN   = 2'd1;
  localparam logic [1:0] REQ_RESTART = 2'd2;

  localparam logic [3:0] PH_TOKEN     = 4'd0;
  localparam logic [3:0] PH_LIT_EXT   = 4'd1;
  localparam logic [3:0] PH_LITERALS  = 4'd2;
  localparam logic [3:0] PH_OFF_LO    = 4'd3;
  localparam logic [3:0] PH_OFF_HI    = 4'd4;
  localparam logic [3:0] PH_MATCH_EXT = 4'd5;
  localparam logic [3:0] PH_COPY      = 4'd6;

  localparam logic [2:0] ST_RUN       = 3'd0;
  localparam logic [2:0] ST_END       = 3'd1;
  localparam logic [2:0] ST_CLEAN     = 3'd2;
  localparam logic [2:0] ST_LIT_OVER  = 3'd3;
  localparam logic [2:0] ST_TRUNC     = 3'd4;
  localparam logic [2:0] ST_BAD_OFF   = 3'd5;
  localparam logic [2:0] ST_MATCH_OVR = 3'd6;

  typedef struct packed {
    logic       lit;
    logic [7:0] lit_byte;
    logic [3:0] count;
    logic [15:0] offset;
    logic       accepted;
    logic       copying;
    logic [2:0] status;
  } slot_t;

  function automatic logic [LEN_W-1:0] sat24(input logic [LEN_W-1:0] a,
                                             input logic [LEN_W-1:0] b);
    logic [LEN_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LEN_W] ? MAX24 : s[LEN_W-1:0];
  endfunction

endpackage

// ===== rtl/core/lz4d_ifs.sv =====
interface lz4d_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] in_byte;
  logic       in_last;
  modport source(output valid, req_type, in_byte, in_last, input ready);
  modport sink(input valid, req_type, in_byte, in_last, output ready);
endinterface

interface lz4d_res_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_data;
  logic [3:0]  out_count;
  logic        accepted;
  logic        copying;
  logic [2:0]  status;
  modport source(output valid, out_data, out_count, accepted, copying, status, input ready);
  modport sink(input valid, out_data, out_count, accepted, copying, status, output ready);
endinterface

interface lz4d_cfg_if;
  logic        valid;
  logic        ready;
  logic [23:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// ===== rtl/core/lz4d_ctrl.sv =====
module lz4d_ctrl import lz4d_pkg::*; #(
  parameter int HISTORY_BYTES = HISTORY_BYTES_DEF,
  parameter int LANE_BYTES    = LANE_BYTES_DEF,
  localparam int AW           = $clog2(HISTORY_BYTES)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  logic [1:0]    req_type,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  input  logic          cfg_we,
  input  logic [23:0]   cfg_data,
  output slot_t         slot,
  output logic [AW-1:0] src_pos,
  output logic [AW-1:0] dst_pos
);

  localparam logic [3:0]  LANE4  = 4'(LANE_BYTES);
  localparam logic [16:0] HIST17 = 17'(HISTORY_BYTES);

  logic [23:0]   output_limit;
  logic [3:0]    phase, phase_next;
  logic [23:0]   literal_left, literal_left_next;
  logic [23:0]   match_left, match_left_next;
  logic [15:0]   match_offset, match_offset_next;
  logic [3:0]    token_low, token_low_next;
  logic [23:0]   produced, produced_next;
  logic [2:0]    stop_code, stop_code_next;
  logic [AW-1:0] ptr, ptr_next;
  logic          saw_last, saw_last_next;

  logic [23:0] lk_len, mk_len;
  logic [15:0] mk_off;
  logic        lk_over, mk_bad, mk_over;
  logic [3:0]  n;
  logic [23:0] ml_after, prod_after;

  assign lk_len  = (phase == PH_TOKEN) ? {20'd0, in_byte[7:4]}
                                       : sat24(literal_left, {16'd0, in_byte});
  assign lk_over = ({1'b0, produced} + {1'b0, lk_len}) > {1'b0, output_limit};
  assign mk_off  = (phase == PH_OFF_HI) ? {in_byte, match_offset[7:0]} : match_offset;
  assign mk_len  = (phase == PH_OFF_HI) ? 24'(token_low) + 24'd4
                                        : sat24(match_left, {16'd0, in_byte});
  assign mk_bad  = ({8'd0, mk_off} > produced) || ({1'b0, mk_off} > HIST17);
  assign mk_over = ({1'b0, produced} + {1'b0, mk_len}) > {1'b0, output_limit};
  assign n          = (match_left < 24'(LANE_BYTES)) ? match_left[3:0] : LANE4;
  assign ml_after   = match_left - 24'(n);
  assign prod_after = sat24(produced, 24'(n));

  always_comb begin
    phase_next        = phase;
    literal_left_next = literal_left;
    match_left_next   = match_left;
    match_offset_next = match_offset;
    token_low_next    = token_low;
    produced_next     = produced;
    stop_code_next    = stop_code;
    ptr_next          = ptr;
    saw_last_next     = saw_last;
    slot              = '0;
    unique case (req_type)
      REQ_RESTART: begin
        phase_next        = PH_TOKEN;
        literal_left_next = '0;
        match_left_next   = '0;
        match_offset_next = '0;
        token_low_next    = '0;
        produced_next     = '0;
        stop_code_next    = ST_RUN;
        ptr_next          = '0;
        saw_last_next     = 1'b0;
      end
      REQ_BYTE: begin
        if (stop_code == ST_RUN && phase != PH_COPY) begin
          if (phase == PH_TOKEN && produced >= output_limit) begin
            stop_code_next = ST_CLEAN;
          end else begin
            slot.accepted = 1'b1;
            unique case (phase)
              PH_TOKEN: begin
                token_low_next    = in_byte[3:0];
                literal_left_next = lk_len;
                if (in_byte[7:4] == 4'd15) begin
                  if (in_last) stop_code_next = ST_TRUNC;
                  else phase_next = PH_LIT_EXT;
                end else if (lk_over) begin
                  stop_code_next = ST_LIT_OVER;
                end else if (in_last) begin
                  stop_code_next = ST_TRUNC;
                end else begin
                  phase_next = (lk_len != '0) ? PH_LITERALS : PH_OFF_LO;
                end
              end
              PH_LIT_EXT: begin
                literal_left_next = lk_len;
                if (in_byte == 8'hFF) begin
                  if (in_last) stop_code_next = ST_TRUNC;
                end else if (lk_over) begin
                  stop_code_next = ST_LIT_OVER;
                end else if (in_last) begin
                  stop_code_next = ST_TRUNC;
                end else begin
                  phase_next = (lk_len != '0) ? PH_LITERALS : PH_OFF_LO;
                end
              end
              PH_LITERALS: begin
                slot.lit          = 1'b1;
                slot.lit_byte     = in_byte;
                slot.count        = 4'd1;
                produced_next     = sat24(produced, 24'd1);
                ptr_next          = ptr + AW'(1);
                literal_left_next = literal_left - 24'd1;
                if (in_last) stop_code_next = ST_TRUNC;
                else if (literal_left == 24'd1) phase_next = PH_OFF_LO;
              end
              PH_OFF_LO: begin
                match_offset_next = {8'd0, in_byte};
                if (in_last) stop_code_next = ST_TRUNC;
                else phase_next = PH_OFF_HI;
              end
              PH_OFF_HI: begin
                match_offset_next = mk_off;
                if (mk_off == '0) begin
                  stop_code_next = ST_END;
                end else begin
                  match_left_next = mk_len;
                  if (token_low == 4'd15) begin
                    if (in_last) stop_code_next = ST_TRUNC;
                    else phase_next = PH_MATCH_EXT;
                  end else if (in_last) begin
                    stop_code_next = ST_TRUNC;
                  end else if (mk_bad) begin
                    stop_code_next = ST_BAD_OFF;
                  end else if (mk_over) begin
                    stop_code_next = ST_MATCH_OVR;
                  end else begin
                    phase_next    = PH_COPY;
                    saw_last_next = 1'b0;
                  end
                end
              end
              PH_MATCH_EXT: begin
                match_left_next = mk_len;
                if (in_byte == 8'hFF) begin
                  if (in_last) stop_code_next = ST_TRUNC;
                end else if (mk_bad) begin
                  stop_code_next = ST_BAD_OFF;
                end else if (mk_over) begin
                  stop_code_next = ST_MATCH_OVR;
                end else begin
                  phase_next    = PH_COPY;
                  saw_last_next = in_last;
                end
              end
              default: ;
            endcase
          end
        end
      end
      REQ_DRAIN: begin
        if (stop_code == ST_RUN && phase == PH_COPY) begin
          slot.count      = n;
          slot.offset     = match_offset;
          match_left_next = ml_after;
          produced_next   = prod_after;
          ptr_next        = ptr + AW'(n);
          if (ml_after == '0) begin
            phase_next    = PH_TOKEN;
            saw_last_next = 1'b0;
            if (saw_last || prod_after >= output_limit) stop_code_next = ST_CLEAN;
          end
        end
      end
      default: ;
    endcase
    slot.status  = stop_code_next;
    slot.copying = (phase_next == PH_COPY) && (stop_code_next == ST_RUN);
  end

  assign src_pos = ptr - match_offset[AW-1:0];
  assign dst_pos = ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_limit <= '0;
      phase        <= PH_TOKEN;
      literal_left <= '0;
      match_left   <= '0;
      match_offset <= '0;
      token_low    <= '0;
      produced     <= '0;
      stop_code    <= ST_RUN;
      ptr          <= '0;
      saw_last     <= 1'b0;
    end else begin
      if (cfg_we) output_limit <= cfg_data;
      if (take) begin
        phase        <= phase_next;
        literal_left <= literal_left_next;
        match_left   <= match_left_next;
        match_offset <= match_offset_next;
        token_low    <= token_low_next;
        produced     <= produced_next;
        stop_code    <= stop_code_next;
        ptr          <= ptr_next;
        saw_last     <= saw_last_next;
      end
    end
  end

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    take && req_type == REQ_RESTART |=> produced == '0 && stop_code == ST_RUN)
    else $error("restart did not clear state");
  a_copy_running: assert property (@(posedge clk) disable iff (rst)
    phase == PH_COPY && stop_code == ST_RUN |-> match_left != '0)
    else $error("copy phase with no match bytes");
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    take && slot.count != '0 |-> ({1'b0, produced} + 25'(slot.count)) <= {1'b0, output_limit})
    else $error("output beyond limit");

endmodule

// ===== rtl/core/lz4d_hist.sv =====
module lz4d_hist import lz4d_pkg::*; #(
  parameter int HISTORY_BYTES = HISTORY_BYTES_DEF,
  parameter int LANE_BYTES    = LANE_BYTES_DEF,
  localparam int AW           = $clog2(HISTORY_BYTES),
  localparam int ROWS         = (1 << AW) / BANKS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  slot_t         slot,
  input  logic [AW-1:0] src_pos,
  input  logic [AW-1:0] dst_pos,
  output logic          in_ready,
  output logic          o_valid,
  input  logic          out_ready,
  output logic [63:0]   o_data,
  output logic [3:0]    o_count,
  output logic          o_accepted,
  output logic          o_copying,
  output logic [2:0]    o_status
);

  logic          b_valid, b_adv;
  slot_t         b_slot;
  logic [2:0]    b_src_lo;
  logic [AW-1:0] b_dst;
  logic [7:0]    rdata [BANKS];
  logic [7:0]    lane [BANKS];
  logic [7:0]    win [BANKS];
  logic [7:0]    win_next [BANKS];
  logic [AW-4:0] rd_row [BANKS];
  logic [AW-4:0] wr_row [BANKS];
  logic [7:0]    wdata [BANKS];
  logic          we [BANKS];
  logic [63:0]   data_next;

  assign b_adv    = b_valid && (!o_valid || out_ready);
  assign in_ready = !b_valid || b_adv;

  always_comb begin
    logic [16:0] back;
    logic [2:0]  idx;
    for (int i = 0; i < BANKS; i++) lane[i] = 8'd0;
    for (int i = 0; i < LANE_BYTES; i++) begin
      back = {1'b0, b_slot.offset} - 17'(i);
      idx  = 3'(i) - b_slot.offset[2:0];
      if (b_slot.lit) begin
        if (i == 0) lane[i] = b_slot.lit_byte;
      end else if ({1'b0, b_slot.offset} <= 17'(i)) begin
        lane[i] = lane[idx];
      end else if (back <= 17'(LANE_BYTES)) begin
        lane[i] = win[3'(back - 17'd1)];
      end else begin
        lane[i] = rdata[b_src_lo + 3'(i)];
      end
    end
  end

  always_comb begin
    logic [2:0] li;
    for (int k = 0; k < BANKS; k++) begin
      li        = 3'(k) - b_dst[2:0];
      we[k]     = b_adv && ({1'b0, li} < b_slot.count);
      wdata[k]  = lane[li];
      wr_row[k] = b_dst[AW-1:3] + ((3'(k) < b_dst[2:0]) ? (AW-3)'(1) : '0);
      rd_row[k] = src_pos[AW-1:3] + ((3'(k) < src_pos[2:0]) ? (AW-3)'(1) : '0);
    end
  end

  for (genvar k = 0; k < BANKS; k++) begin : g_bank
    logic [7:0] mem [ROWS];
    always_ff @(posedge clk) begin
      if (we[k]) mem[wr_row[k]] <= wdata[k];
      if (take) rdata[k] <= mem[rd_row[k]];
    end
  end

  always_comb begin
    for (int j = 0; j < BANKS; j++) begin
      if (4'(j) < b_slot.count) win_next[j] = lane[3'(b_slot.count - 4'd1 - 4'(j))];
      else win_next[j] = win[3'(4'(j) - b_slot.count)];
    end
    for (int i = 0; i < BANKS; i++) begin
      data_next[8*i +: 8] = (4'(i) < b_slot.count) ? lane[i] : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      b_valid <= take || (b_valid && !b_adv);
      o_valid <= b_adv || (o_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      b_slot   <= slot;
      b_src_lo <= src_pos[2:0];
      b_dst    <= dst_pos;
    end
    if (b_adv) begin
      win        <= win_next;
      o_data     <= data_next;
      o_count    <= b_slot.count;
      o_accepted <= b_slot.accepted;
      o_copying  <= b_slot.copying;
      o_status   <= b_slot.status;
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    o_valid |-> o_count <= 4'(LANE_BYTES))
    else $error("word count above lane count");
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    b_valid && !b_adv |=> b_valid && $stable(b_slot))
    else $error("stalled stage lost its item");
  a_adv_fills: assert property (@(posedge clk) disable iff (rst)
    b_adv |=> o_valid)
    else $error("advanced item not presented");

endmodule

// ===== rtl/core/lz4_block_decompressor.sv =====
// Accepted requests go to a buffer register, then to the output register once it is free.
// One request per cycle unless output stalls; a drain delivers up to LANE_BYTES match bytes.
// History sits in eight byte-wide banks, read on acceptance, written when the item advances;
// the previous word's bytes are forwarded from a small window register.
// Reset (synchronous, rst high) clears control state and output_limit; history is not cleared.
module lz4_block_decompressor import lz4d_pkg::*; #(
  parameter int HISTORY_BYTES = HISTORY_BYTES_DEF,
  parameter int LANE_BYTES    = LANE_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  lz4d_req_if.sink   req,
  lz4d_res_if.source res,
  lz4d_cfg_if.sink   cfg
);

  localparam int AW = $clog2(HISTORY_BYTES);

  logic          take;
  slot_t         slot;
  logic [AW-1:0] src_pos, dst_pos;
  logic          in_ready;

  assign take      = req.valid && in_ready;
  assign req.ready = in_ready;
  assign cfg.ready = 1'b1;

  lz4d_ctrl #(.HISTORY_BYTES(HISTORY_BYTES), .LANE_BYTES(LANE_BYTES)) u_ctrl (
    .clk(clk), .rst(rst), .take(take),
    .req_type(req.req_type), .in_byte(req.in_byte), .in_last(req.in_last),
    .cfg_we(cfg.valid), .cfg_data(cfg.data),
    .slot(slot), .src_pos(src_pos), .dst_pos(dst_pos)
  );

  lz4d_hist #(.HISTORY_BYTES(HISTORY_BYTES), .LANE_BYTES(LANE_BYTES)) u_hist (
    .clk(clk), .rst(rst), .take(take), .slot(slot),
    .src_pos(src_pos), .dst_pos(dst_pos), .in_ready(in_ready),
    .o_valid(res.valid), .out_ready(res.ready),
    .o_data(res.out_data), .o_count(res.out_count),
    .o_accepted(res.accepted), .o_copying(res.copying), .o_status(res.status)
  );

endmodule
